// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the AIS position report packer RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AISPRP_ASSERT_NOW(label, ante, cons, text) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(text);

// Consequent must hold in the cycle after the antecedent.
`define AISPRP_ASSERT_NEXT(label, ante, cons, text) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(text);

`endif

// ----- rtl/aisprp_pkg.sv -----
// Package for the AIS position report packer: field types, message constants,
// reciprocal constants for the fixed divisions and the rate-of-turn threshold table.
// No dependencies.
package aisprp_pkg;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_STATION_ID,
        CFG_REPORT_TYPE
    } t_cfg_idx;

    localparam int CFG_DATA_W = 30;

    // Input field types.
    typedef logic signed [7:0]  t_status;
    typedef logic signed [15:0] t_turn;
    typedef logic signed [15:0] t_speed;
    typedef logic signed [31:0] t_lon;
    typedef logic signed [30:0] t_lat;
    typedef logic signed [16:0] t_angle;
    typedef logic [16:0]        t_day_sec;

    // Message framing.
    localparam int        MSG_W     = 168;
    localparam int        GRP_W     = 6;
    localparam logic [4:0] LAST_GRP = 5'd27;

    // Message type codes.
    localparam logic [7:0] TYPE_MIN     = 8'd1;
    localparam logic [7:0] TYPE_MAX     = 8'd3;
    localparam logic [5:0] TYPE_DEFAULT = 6'd1;

    // Field limits and values sent without a position fix.
    localparam logic [3:0]  STATUS_MAX  = 4'd15;
    localparam logic [9:0]  SPEED_MAX   = 10'd1022;
    localparam logic [9:0]  SPEED_NOFIX = 10'd1023;
    localparam logic [11:0] COG_MAX     = 12'd3599;
    localparam logic [11:0] COG_NOFIX   = 12'd3600;
    localparam logic [8:0]  HDG_MAX     = 9'd359;
    localparam logic [27:0] LON_NOFIX   = 28'd108600000;
    localparam logic [26:0] LAT_NOFIX   = 27'd54600000;

    // Reciprocals: floor(x / d) == (x * RECIP) >> SHIFT over the operand ranges used.
    localparam logic [16:0] RECIP10        = 17'd104858;
    localparam int          RECIP10_SHIFT  = 20;
    localparam logic [17:0] RECIP100       = 18'd167773;
    localparam int          RECIP100_SHIFT = 24;
    localparam logic [17:0] RECIP60        = 18'd139811;
    localparam int          RECIP60_SHIFT  = 23;
    localparam logic [31:0] RECIP50        = 32'd2748779070;
    localparam int          RECIP50_SHIFT  = 37;

    localparam logic [16:0] SEC_PER_MIN = 17'd60;
    localparam logic [31:0] DIV50       = 32'd50;

    // Rate of turn: count of k in 0..125 with TURN_DEN * mag >= TURN_NUM * (2k+1)^2.
    localparam int      TURN_STEPS = 126;
    localparam longint  TURN_NUM   = 64'd10000000;
    localparam longint  TURN_DEN   = 64'd89605156;

    typedef logic [16:0] t_turn_thr [128];

    // Smallest magnitude that passes each threshold; unused tail entries never pass.
    function automatic t_turn_thr make_turn_thr();
        t_turn_thr thr;
        longint    odd;
        for (int k = 0; k < 128; k++) begin
            odd = longint'(2 * k + 1);
            if (k < TURN_STEPS) begin
                thr[k] = 17'((odd * odd * TURN_NUM + TURN_DEN - 64'd1) / TURN_DEN);
            end else begin
                thr[k] = '1;
            end
        end
        return thr;
    endfunction

    localparam t_turn_thr TURN_THR = make_turn_thr();

    // Binary search over the monotonic threshold table.
    function automatic logic [6:0] turn_mag_code(logic [16:0] mag);
        logic [6:0] cnt;
        logic [6:0] cand;
        cnt = '0;
        for (int b = 6; b >= 0; b--) begin
            cand = cnt | (7'd1 << b);
            if (mag >= TURN_THR[cand - 7'd1]) begin
                cnt = cand;
            end
        end
        return cnt;
    endfunction

    // Rounding term (3r + 25) / 50 for a remainder r below 50.
    function automatic logic [1:0] round_rem50(logic [5:0] rem);
        logic [7:0] t;
        t = 8'(rem) * 8'd3 + 8'd25;
        if (t >= 8'd150) begin
            return 2'd3;
        end else if (t >= 8'd100) begin
            return 2'd2;
        end else if (t >= 8'd50) begin
            return 2'd1;
        end
        return 2'd0;
    endfunction

endpackage

// ----- rtl/aisprp_fix_if.sv -----
// Input channel of the AIS position report packer: one vessel fix per transfer.
// Depends on aisprp_pkg for the field types.
interface aisprp_fix_if import aisprp_pkg::*; ();
    logic     valid;
    logic     ready;
    logic     has_fix;
    logic     differential;
    t_status  nav_status;
    t_turn    turn_rate;
    t_speed   ground_speed;
    t_lon     longitude;
    t_lat     latitude;
    t_angle   ground_course;
    t_angle   true_heading;
    t_day_sec day_second;

    modport source (
        output valid, has_fix, differential, nav_status, turn_rate, ground_speed,
               longitude, latitude, ground_course, true_heading, day_second,
        input  ready
    );
    modport sink (
        input  valid, has_fix, differential, nav_status, turn_rate, ground_speed,
               longitude, latitude, ground_course, true_heading, day_second,
        output ready
    );
endinterface

// ----- rtl/aisprp_grp_if.sv -----
// Output channel of the AIS position report packer: one six-bit group per transfer.
// No dependencies.
interface aisprp_grp_if ();
    logic       valid;
    logic       ready;
    logic [5:0] six_bit_group;
    logic       last_group;

    modport source (
        output valid, six_bit_group, last_group,
        input  ready
    );
    modport sink (
        input  valid, six_bit_group, last_group,
        output ready
    );
endinterface

// ----- rtl/ais_position_report_packer.sv -----
// Channel   Dir  Handshake     Payload
// i_fix     in   valid/ready   has_fix .. day_second, one fix per transfer
// o_grp     out  valid/ready   six_bit_group, last_group, 28 transfers per fix
// i_cfg_*   in   write enable  station_id, report_type
//
// A report leaves as 28 groups, one per cycle while o_grp.ready is high, from the
// output shift register. An input transfer reaches the first group through the
// input, product and message registers in turn.
// A new fix is taken while the current report is still shifting out.
// Synchronous active-low reset empties all stages; stalls on o_grp hold the message stage.
//
// Top level of the AIS position report packer; uses aisprp_pkg, the two channel
// interfaces and assert_macros.svh.
`include "assert_macros.svh"

module ais_position_report_packer import aisprp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    aisprp_fix_if.sink            i_fix,
    aisprp_grp_if.source          o_grp
);

    // Configuration registers.
    logic [29:0] r_station_id;
    logic [7:0]  r_report_type;

    // Stage A: captured fix.
    logic     r_a_vld;
    logic     r_a_fix;
    logic     r_a_diff;
    t_status  r_a_status;
    t_turn    r_a_turn;
    t_speed   r_a_speed;
    t_lon     r_a_lon;
    t_lat     r_a_lat;
    t_angle   r_a_cog;
    t_angle   r_a_hdg;
    t_day_sec r_a_sec;

    // Stage B: quotients from the reciprocal multiplies.
    logic        r_b_vld;
    logic        r_b_fix;
    logic        r_b_diff;
    t_status     r_b_status;
    logic        r_b_turn_neg;
    logic [6:0]  r_b_turn_mag;
    logic [11:0] r_b_spd_q;
    logic [12:0] r_b_cog_q;
    logic [9:0]  r_b_hdg_q;
    t_day_sec    r_b_sec;
    logic [11:0] r_b_sec_q;
    logic        r_b_lon_neg;
    logic [31:0] r_b_lon_mag;
    logic [25:0] r_b_lon_q;
    logic        r_b_lat_neg;
    logic [30:0] r_b_lat_mag;
    logic [24:0] r_b_lat_q;

    // Stage C: message shift register.
    logic             r_c_vld;
    logic [4:0]       r_c_cnt;
    logic [MSG_W-1:0] r_c_msg;

    // Handshake and stage movement.
    logic a_load, b_load, c_load, c_xfer, c_last;

    assign c_xfer = r_c_vld && o_grp.ready;
    assign c_last = (r_c_cnt == LAST_GRP);
    assign c_load = r_b_vld && (!r_c_vld || (c_xfer && c_last));
    assign b_load = r_a_vld && (!r_b_vld || c_load);
    assign i_fix.ready = !r_a_vld || b_load;
    assign a_load = i_fix.valid && i_fix.ready;

    assign o_grp.valid         = r_c_vld;
    assign o_grp.six_bit_group = r_c_msg[MSG_W-1 -: GRP_W];
    assign o_grp.last_group    = c_last;

    // Stage A to B: magnitudes, rounding offsets and reciprocal products.
    logic [16:0] n_b_turn_abs;
    logic [6:0]  n_b_turn_mag;
    logic [15:0] spd_x;
    logic [32:0] spd_prod;
    logic [16:0] cog_x;
    logic [33:0] cog_prod;
    logic [16:0] hdg_x;
    logic [34:0] hdg_prod;
    logic [34:0] sec_prod;
    logic [31:0] n_b_lon_mag;
    logic [63:0] lon_prod;
    logic [30:0] n_b_lat_mag;
    logic [63:0] lat_prod;

    always_comb begin
        n_b_turn_abs = r_a_turn[15] ? 17'(17'sd0 - 17'(r_a_turn)) : 17'(r_a_turn);
        n_b_turn_mag = turn_mag_code(n_b_turn_abs);

        // Negative speed, course and heading all round to zero or below and clamp to zero.
        spd_x    = r_a_speed[15] ? 16'd0 : 16'({1'b0, r_a_speed[14:0]}) + 16'd5;
        spd_prod = 33'(spd_x) * 33'(RECIP10);
        cog_x    = r_a_cog[16] ? 17'd0 : 17'({1'b0, r_a_cog[15:0]}) + 17'd5;
        cog_prod = 34'(cog_x) * 34'(RECIP10);
        hdg_x    = r_a_hdg[16] ? 17'd0 : 17'({1'b0, r_a_hdg[15:0]}) + 17'd50;
        hdg_prod = 35'(hdg_x) * 35'(RECIP100);
        sec_prod = 35'(r_a_sec) * 35'(RECIP60);

        n_b_lon_mag = r_a_lon[31] ? 32'(33'sd0 - 33'(r_a_lon)) : 32'(r_a_lon);
        lon_prod    = 64'(n_b_lon_mag) * 64'(RECIP50);
        n_b_lat_mag = r_a_lat[30] ? 31'(32'sd0 - 32'(r_a_lat)) : 31'(r_a_lat);
        lat_prod    = 64'(n_b_lat_mag) * 64'(RECIP50);
    end

    // Stage B to C: remainders, saturation and message assembly.
    logic [5:0]       lon_rem;
    logic [27:0]      lon_abs;
    logic [27:0]      lon_field;
    logic [5:0]       lat_rem;
    logic [26:0]      lat_abs;
    logic [26:0]      lat_field;
    logic [16:0]      sec_rem;
    logic [5:0]       type_field;
    logic [3:0]       status_field;
    logic [7:0]       turn_field;
    logic [9:0]       speed_field;
    logic [11:0]      cog_field;
    logic [8:0]       hdg_field;
    logic             acc_field;
    logic [MSG_W-1:0] n_c_msg;

    always_comb begin
        // |value| * 3 / 50 rounded = 3q + round(3r / 50), with |value| = 50q + r.
        lon_rem = 6'(r_b_lon_mag - 32'(r_b_lon_q) * DIV50);
        lon_abs = 28'(r_b_lon_q) * 28'd3 + 28'(round_rem50(lon_rem));
        lat_rem = 6'(32'(r_b_lat_mag) - 32'(r_b_lat_q) * DIV50);
        lat_abs = 27'(r_b_lat_q) * 27'd3 + 27'(round_rem50(lat_rem));

        if (!r_b_fix) begin
            lon_field = LON_NOFIX;
            lat_field = LAT_NOFIX;
        end else begin
            lon_field = r_b_lon_neg ? 28'(28'd0 - lon_abs) : lon_abs;
            lat_field = r_b_lat_neg ? 27'(27'd0 - lat_abs) : lat_abs;
        end

        sec_rem = r_b_sec - 17'(r_b_sec_q) * SEC_PER_MIN;

        if (r_report_type >= TYPE_MIN && r_report_type <= TYPE_MAX) begin
            type_field = r_report_type[5:0];
        end else begin
            type_field = TYPE_DEFAULT;
        end

        if (r_b_status[7]) begin
            status_field = 4'd0;
        end else if (r_b_status > $signed({4'd0, STATUS_MAX})) begin
            status_field = STATUS_MAX;
        end else begin
            status_field = r_b_status[3:0];
        end

        turn_field = r_b_turn_neg ? 8'(8'd0 - {1'b0, r_b_turn_mag}) : {1'b0, r_b_turn_mag};

        if (!r_b_fix) begin
            speed_field = SPEED_NOFIX;
        end else if (r_b_spd_q > 12'(SPEED_MAX)) begin
            speed_field = SPEED_MAX;
        end else begin
            speed_field = r_b_spd_q[9:0];
        end

        if (!r_b_fix) begin
            cog_field = COG_NOFIX;
        end else if (r_b_cog_q > 13'(COG_MAX)) begin
            cog_field = COG_MAX;
        end else begin
            cog_field = r_b_cog_q[11:0];
        end

        hdg_field = (r_b_hdg_q > 10'(HDG_MAX)) ? HDG_MAX : r_b_hdg_q[8:0];
        acc_field = r_b_fix && r_b_diff;

        // Repeat indicator, manoeuvre, spare, RAIM and radio status are sent as zero.
        n_c_msg = {type_field, 2'b00, r_station_id, status_field, turn_field,
                   speed_field, acc_field, lon_field, lat_field, cog_field,
                   hdg_field, sec_rem[5:0], 2'b00, 3'b000, 1'b0, 19'd0};
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id  <= '0;
            r_report_type <= 8'd1;
            r_a_vld       <= 1'b0;
            r_b_vld       <= 1'b0;
            r_c_vld       <= 1'b0;
            r_c_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_STATION_ID:  r_station_id  <= i_cfg_data[29:0];
                    CFG_REPORT_TYPE: r_report_type <= i_cfg_data[7:0];
                endcase
            end
            r_a_vld <= a_load || (r_a_vld && !b_load);
            r_b_vld <= b_load || (r_b_vld && !c_load);
            r_c_vld <= c_load || (r_c_vld && !(c_xfer && c_last));
            if (c_load) begin
                r_c_cnt <= '0;
            end else if (c_xfer) begin
                r_c_cnt <= r_c_cnt + 5'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_fix    <= i_fix.has_fix;
            r_a_diff   <= i_fix.differential;
            r_a_status <= i_fix.nav_status;
            r_a_turn   <= i_fix.turn_rate;
            r_a_speed  <= i_fix.ground_speed;
            r_a_lon    <= i_fix.longitude;
            r_a_lat    <= i_fix.latitude;
            r_a_cog    <= i_fix.ground_course;
            r_a_hdg    <= i_fix.true_heading;
            r_a_sec    <= i_fix.day_second;
        end
        if (b_load) begin
            r_b_fix      <= r_a_fix;
            r_b_diff     <= r_a_diff;
            r_b_status   <= r_a_status;
            r_b_turn_neg <= r_a_turn[15];
            r_b_turn_mag <= n_b_turn_mag;
            r_b_spd_q    <= 12'(spd_prod >> RECIP10_SHIFT);
            r_b_cog_q    <= 13'(cog_prod >> RECIP10_SHIFT);
            r_b_hdg_q    <= 10'(hdg_prod >> RECIP100_SHIFT);
            r_b_sec      <= r_a_sec;
            r_b_sec_q    <= 12'(sec_prod >> RECIP60_SHIFT);
            r_b_lon_neg  <= r_a_lon[31];
            r_b_lon_mag  <= n_b_lon_mag;
            r_b_lon_q    <= 26'(lon_prod >> RECIP50_SHIFT);
            r_b_lat_neg  <= r_a_lat[30];
            r_b_lat_mag  <= n_b_lat_mag;
            r_b_lat_q    <= 25'(lat_prod >> RECIP50_SHIFT);
        end
        if (c_load) begin
            r_c_msg <= n_c_msg;
        end else if (c_xfer) begin
            r_c_msg <= r_c_msg << GRP_W;
        end
    end

    `AISPRP_ASSERT_NEXT(a_grp_count_step, c_xfer && !c_last, r_c_vld && (r_c_cnt == $past(r_c_cnt) + 5'd1), "group counter did not advance on a transfer")
    `AISPRP_ASSERT_NEXT(a_report_kept, r_c_vld && !(c_xfer && c_last), r_c_vld, "report dropped before its last group")
    `AISPRP_ASSERT_NOW(a_grp_count_range, r_c_vld, r_c_cnt <= LAST_GRP, "group counter beyond last group")
    `AISPRP_ASSERT_NEXT(a_fix_kept, r_a_vld && !b_load, r_a_vld, "captured fix lost while stalled")

endmodule
